@@ rtl/lds_pkg.sv @@
package lds_pkg;

	// position counter width and alphabet size
	localparam int unsigned POSITION_BITS = 16;
	localparam int unsigned ALPHABET_SIZE = 256;
	localparam int unsigned SYM_BITS      = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;

	// result lengths are 1..256
	localparam int unsigned LEN_BITS = 9;
	localparam logic [LEN_BITS-1:0] LEN_CAP = LEN_BITS'(256);

	localparam int unsigned BYTE_BITS = 8;

	// reciprocal for folding a byte onto the alphabet
	localparam logic [16:0] SYM_RECIP = 17'((65536 + ALPHABET_SIZE - 1) / ALPHABET_SIZE);
	localparam logic [15:0] ALPHA_W   = 16'(ALPHABET_SIZE);
	localparam bit ALPHA_POW2 = ((ALPHABET_SIZE & (ALPHABET_SIZE - 1)) == 0);

	typedef logic [SYM_BITS-1:0]      sym_t;
	typedef logic [POSITION_BITS-1:0] pos_t;
	typedef logic [LEN_BITS-1:0]      len_t;

	typedef struct packed {
		len_t window_length;
		len_t best_length;
		logic string_done;
		logic length_overflow;
	} lds_result_t;

	typedef struct packed {
		logic wr_en;
		sym_t wr_addr;
		pos_t wr_data;
	} lds_wr_t;

	// byte value modulo the alphabet size
	function automatic sym_t fold_sym(input logic [BYTE_BITS-1:0] v);
		logic [24:0] prod;
		logic [15:0] quot;
		logic [15:0] rem;
		prod = 25'(v) * 25'(SYM_RECIP);
		quot = 16'(prod[23:16]);
		rem  = 16'(v) - quot * ALPHA_W;
		if (ALPHA_POW2)
			return v[SYM_BITS-1:0];
		else
			return rem[SYM_BITS-1:0];
	endfunction

endpackage

@@ rtl/lds_pos_ram.sv @@
module lds_pos_ram
	import lds_pkg::*;
(
	input  logic    clk,
	input  logic    rd_en,
	input  sym_t    rd_addr,
	output pos_t    rd_data,
	input  lds_wr_t wr
);

	pos_t mem [ALPHABET_SIZE];

	always_ff @(posedge clk) begin
		if (wr.wr_en) begin
			mem[wr.wr_addr] <= wr.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ rtl/lds_window.sv @@
module lds_window
	import lds_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,
	input  sym_t        sym_s1,
	input  logic        last_s1,
	input  pos_t        rd_data,
	output lds_wr_t     wr,
	output lds_result_t result
);

	logic [ALPHABET_SIZE-1:0] seen_q;
	pos_t  pos_q;
	pos_t  start_q;
	len_t  best_q;
	logic  ovf_q;

	// most recent table write, covers a read issued on the same edge
	sym_t  lw_sym_q;
	pos_t  lw_pos_q;

	pos_t  prev;
	pos_t  d_prev;
	pos_t  d_cur;
	logic  hit;
	pos_t  start_nx;
	pos_t  span;
	len_t  wlen;
	len_t  best_nx;
	pos_t  pos_nx;

	always_comb begin
		prev     = (lw_sym_q == sym_s1) ? lw_pos_q : rd_data;
		d_prev   = prev - start_q;
		d_cur    = pos_q - start_q;
		hit      = seen_q[sym_s1] && (d_prev < d_cur);
		start_nx = hit ? (prev + pos_t'(1)) : start_q;
		span     = pos_q - start_nx;
		if ((|span[POSITION_BITS-1:8]) || (&span[7:0]))
			wlen = LEN_CAP;
		else
			wlen = len_t'(span[7:0]) + len_t'(1);
		best_nx = (wlen > best_q) ? wlen : best_q;
		pos_nx  = pos_q + pos_t'(1);
	end

	assign wr.wr_en   = advance;
	assign wr.wr_addr = sym_s1;
	assign wr.wr_data = pos_q;

	assign result.window_length   = wlen;
	assign result.best_length     = best_nx;
	assign result.string_done     = last_s1;
	assign result.length_overflow = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= '0;
			pos_q   <= '0;
			start_q <= '0;
			best_q  <= '0;
			ovf_q   <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				seen_q  <= '0;
				pos_q   <= '0;
				start_q <= '0;
				best_q  <= '0;
				ovf_q   <= 1'b0;
			end else begin
				seen_q[sym_s1] <= 1'b1;
				pos_q          <= pos_nx;
				start_q        <= start_nx;
				best_q         <= best_nx;
				if (pos_nx == '0) begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			lw_sym_q <= sym_s1;
			lw_pos_q <= pos_q;
		end
	end

endmodule

@@ rtl/longest_distinct_run_scanner_core.sv @@
// longest repeat-free run scanner: takes a string one byte per transfer on the
// slave stream, with tlast on the final byte, and returns one transfer per byte
// on the master stream carrying the length of the repeat-free window ending at
// that byte and the best such length so far in the string. tlast on the output
// marks the byte whose best length is the final answer. tuser flags a string
// whose position counter wrapped; its lengths are then unreliable. a new byte
// is taken every cycle while the master side keeps up; each result passes
// through stage 1 and the output register before it is offered on the master
// stream. stage 1 waits on the last-seen-position table: a synchronous memory
// read in the accept cycle and written back when the byte leaves stage 1, with
// a bypass of the latest write so that equal bytes back to back still see each
// other. the table has no clearing pass: per-entry valid bits in flops are
// cleared at once after the last byte of each string and at reset.
module longest_distinct_run_scanner_core
	import lds_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
	input  logic        s_axis_tlast,   // is_last

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [8:0] window_length, [17:9] best_length, rest zero
	output logic        m_axis_tlast,   // string_done
	output logic [0:0]  m_axis_tuser    // [0] length_overflow
);

	// stage 1: byte waiting for its table read data
	logic        s1_valid_q;
	sym_t        sym_s1;
	logic        last_s1;

	// output register
	logic        m_valid_q;
	lds_result_t res_q;

	logic        accept;
	logic        advance;
	sym_t        sym_in;
	pos_t        rd_data;
	lds_wr_t     wr;
	lds_result_t result;

	assign sym_in        = fold_sym(s_axis_tdata);
	// stage 1 moves on whenever the output register is empty or drains
	assign advance       = s1_valid_q && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = !s1_valid_q || advance;
	assign accept        = s_axis_tvalid && s_axis_tready;

	lds_pos_ram u_ram (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (sym_in),
		.rd_data (rd_data),
		.wr      (wr)
	);

	lds_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.sym_s1  (sym_s1),
		.last_s1 (last_s1),
		.rd_data (rd_data),
		.wr      (wr),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			if (accept)
				s1_valid_q <= 1'b1;
			else if (advance)
				s1_valid_q <= 1'b0;
			if (advance)
				m_valid_q <= 1'b1;
			else if (m_axis_tready)
				m_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			sym_s1  <= sym_in;
			last_s1 <= s_axis_tlast;
		end
		if (advance) begin
			res_q <= result;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {6'd0, res_q.best_length, res_q.window_length};
	assign m_axis_tlast  = res_q.string_done;
	assign m_axis_tuser  = res_q.length_overflow;

endmodule

@@ rtl/lds_checker.sv @@
module lds_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic        m_axis_tlast,
	input logic [0:0]  m_axis_tuser
);

	// next output transfer belongs to the first byte of a string
	logic new_string_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			new_string_q <= 1'b1;
		end else if (m_axis_tvalid && m_axis_tready) begin
			new_string_q <= m_axis_tlast;
		end
	end

	// current window never beats the running best
	a_window_le_best: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[8:0] <= m_axis_tdata[17:9]))
		else $error("window length above best length");

	// window length is always 1..256
	a_window_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[8:0] != 9'd0 && m_axis_tdata[8:0] <= 9'd256))
		else $error("window length out of range");

	// first byte of a string starts a fresh window
	a_fresh_string: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && new_string_q) |->
		(m_axis_tdata[8:0] == 9'd1 && m_axis_tdata[17:9] == 9'd1))
		else $error("first byte of a string without lengths of one");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
		(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
		&& $stable(m_axis_tuser)))
		else $error("output changed while stalled");

endmodule

bind longest_distinct_run_scanner_core lds_checker u_lds_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);

@@ test/run_length_checker.sv @@
`timescale 1ns / 1ps

// watches both streams of the scanner, predicts each result from the accepted
// bytes and compares every output transfer with the oldest prediction
module run_length_checker
	import lds_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic        s_axis_tlast,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [23:0] m_axis_tdata,
	input  logic        m_axis_tlast,
	input  logic [0:0]  m_axis_tuser,
	output int          mismatches,
	output int          outstanding
);

	// predicted scanner state
	pos_t seen_pos [ALPHABET_SIZE];
	bit   seen_valid [ALPHABET_SIZE];
	pos_t next_pos;
	pos_t win_start;
	len_t best_len;
	bit   wrapped;

	lds_result_t expected_lengths [$];

	function automatic void clear_run_state();
		for (int k = 0; k < ALPHABET_SIZE; k++) begin
			seen_pos[k]   = '0;
			seen_valid[k] = 1'b0;
		end
		next_pos  = '0;
		win_start = '0;
		best_len  = '0;
		wrapped   = 1'b0;
	endfunction

	function automatic lds_result_t predict_window(input logic [7:0] b, input logic last);
		lds_result_t r;
		int unsigned sym;
		pos_t pos;
		pos_t prev;
		pos_t span;
		logic [POSITION_BITS:0] wlen;
		sym = b % ALPHABET_SIZE;
		pos = next_pos;
		r.length_overflow = wrapped;
		// an earlier copy inside the window pulls the start just past it
		if (seen_valid[sym]) begin
			prev = seen_pos[sym];
			if (pos_t'(prev - win_start) < pos_t'(pos - win_start))
				win_start = pos_t'(prev + 1'b1);
		end
		seen_pos[sym]   = pos;
		seen_valid[sym] = 1'b1;
		span = pos_t'(pos - win_start);
		wlen = {1'b0, span} + 1'b1;
		if (wlen > (POSITION_BITS+1)'(LEN_CAP))
			wlen = (POSITION_BITS+1)'(LEN_CAP);
		if (len_t'(wlen) > best_len)
			best_len = len_t'(wlen);
		r.window_length = len_t'(wlen);
		r.best_length   = best_len;
		r.string_done   = last;
		// wrap to zero flags the rest of the string
		next_pos = pos_t'(pos + 1'b1);
		if (next_pos == '0)
			wrapped = 1'b1;
		if (last)
			clear_run_state();
		return r;
	endfunction

	lds_result_t got;
	lds_result_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_run_state();
			expected_lengths.delete();
			outstanding = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.window_length   = m_axis_tdata[8:0];
				got.best_length     = m_axis_tdata[17:9];
				got.string_done     = m_axis_tlast;
				got.length_overflow = m_axis_tuser[0];
				if (expected_lengths.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result, nothing pending: wl=%0d best=%0d done=%0b ovf=%0b",
						$time, got.window_length, got.best_length, got.string_done,
						got.length_overflow);
				end else begin
					want = expected_lengths.pop_front();
					if (got.window_length !== want.window_length ||
							got.best_length !== want.best_length ||
							got.string_done !== want.string_done ||
							got.length_overflow !== want.length_overflow) begin
						mismatches++;
						$display("%0t: mismatch expected wl=%0d best=%0d done=%0b ovf=%0b",
							$time, want.window_length, want.best_length, want.string_done,
							want.length_overflow);
						$display("%0t:          actual   wl=%0d best=%0d done=%0b ovf=%0b",
							$time, got.window_length, got.best_length, got.string_done,
							got.length_overflow);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_lengths.push_back(predict_window(s_axis_tdata, s_axis_tlast));
			outstanding = expected_lengths.size();
		end
	end

endmodule

@@ test/tb_longest_distinct_run_scanner_core.sv @@
`timescale 1ns / 1ps

module tb_longest_distinct_run_scanner_core;

	localparam int CYCLE_LIMIT    = 2000000;
	localparam int HOLDOFF_CYCLES = 400;
	localparam int RANDOM_BYTES   = 700;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic [0:0]  m_axis_tuser;

	int mismatches;
	int outstanding;
	int cycle_count;
	int holdoff_asked;
	int holdoff_served;
	bit idle_mode;

	longest_distinct_run_scanner_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser)
	);

	run_length_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last);
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic idle_gap(input int n);
		repeat (n) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
	endtask

	task automatic send_paced(input logic [7:0] b, input logic last);
		if (idle_mode)
			idle_gap(pick_gap());
		send_byte(b, last);
	endtask

	task automatic send_text(input string txt);
		for (int i = 0; i < txt.len(); i++)
			send_paced(8'(txt[i]), i == txt.len() - 1);
	endtask

	// byte styles: full range, a tiny set, a medium set, a sweep with stray repeats
	task automatic send_random_string(input int len);
		int style;
		int span;
		logic [7:0] base;
		logic [7:0] b;
		style = $urandom_range(0, 3);
		base  = 8'($urandom);
		span  = (style == 1) ? $urandom_range(1, 7) : $urandom_range(8, 63);
		for (int i = 0; i < len; i++) begin
			case (style)
				0: b = 8'($urandom);
				3: b = ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'(base + i);
				default: b = 8'(base + $urandom_range(0, span));
			endcase
			send_paced(b, i == len - 1);
		end
	endtask

	task automatic drain_results();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	// result side: ready runs broken by stalls, plus the long hold-off on request
	initial begin : result_sink
		int run;
		holdoff_served = 0;
		m_axis_tready  = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (holdoff_served != holdoff_asked) begin
				repeat (HOLDOFF_CYCLES) begin
					@(negedge clk);
					m_axis_tready <= 1'b0;
				end
				holdoff_served++;
			end
			run = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
			repeat (run) begin
				@(negedge clk);
				m_axis_tready <= 1'b1;
			end
			repeat (pick_gap()) begin
				@(negedge clk);
				m_axis_tready <= 1'b0;
			end
		end
	end

	// run limit
	initial begin
		cycle_count = 0;
		while (cycle_count <= CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin : byte_source
		int random_sent;
		int len;
		bit paused;
		holdoff_asked  = 0;
		idle_mode      = 1'b1;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = 8'h00;
		s_axis_tlast   = 1'b0;
		arst_n         = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: single-byte strings at both byte extremes, classic repeats,
		// equal bytes back to back, high bit toggling
		send_paced(8'h00, 1'b1);
		send_paced(8'hFF, 1'b1);
		send_text("abcabcbb");
		send_paced(8'd7, 1'b0);
		send_paced(8'd7, 1'b0);
		send_paced(8'd7, 1'b1);
		send_text("pwwkew");
		send_paced(8'd128, 1'b0);
		send_paced(8'd127, 1'b0);
		send_paced(8'd0, 1'b0);
		send_paced(8'd255, 1'b0);
		send_paced(8'd128, 1'b1);
		drain_results();

		// every byte value once, so the window reaches its full length, then a repeat
		idle_mode = 1'b0;
		for (int i = 0; i < 256; i++)
			send_byte(8'(i), 1'b0);
		send_byte(8'd0, 1'b0);
		send_byte(8'd1, 1'b1);
		send_text("overflow cleared");
		drain_results();

		// random strings, starting with a long receiver hold-off under full load
		random_sent = 0;
		paused      = 1'b0;
		holdoff_asked++;
		send_random_string(300);
		random_sent += 300;
		while (random_sent < RANDOM_BYTES) begin
			if (!paused && random_sent > RANDOM_BYTES / 2) begin
				drain_results();
				paused = 1'b1;
			end
			idle_mode = ($urandom_range(0, 3) != 0);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 300) : $urandom_range(1, 24);
			send_random_string(len);
			random_sent += len;
		end

		drain_results();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/lds_pkg.sv
rtl/lds_pos_ram.sv
rtl/lds_window.sv
rtl/longest_distinct_run_scanner_core.sv
rtl/lds_checker.sv
test/run_length_checker.sv
test/tb_longest_distinct_run_scanner_core.sv
